### rtl/zcl_arp_pkg.sv
// Shared types, type codes and decode helpers for the attribute record parser.
package zcl_arp_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int TDATA_OUT_BITS    = 128;

  // Data type codes that get special handling
  localparam logic [7:0] DT_NONE     = 8'h00;
  localparam logic [7:0] DT_BOOL     = 8'h10;
  localparam logic [7:0] DT_FLOAT32  = 8'h39;
  localparam logic [7:0] DT_OCTSTR   = 8'h41;
  localparam logic [7:0] DT_CHARSTR  = 8'h42;
  localparam logic [7:0] DT_LOCTSTR  = 8'h43;
  localparam logic [7:0] DT_LCHARSTR = 8'h44;
  localparam logic [7:0] DT_INT8     = 8'h28;
  localparam logic [7:0] DT_INT64    = 8'h2F;

  typedef enum logic [1:0] {
    RK_RECORD  = 2'd0,
    RK_END_OK  = 2'd1,
    RK_END_ERR = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    VK_NONE     = 3'd0,
    VK_BOOL     = 3'd1,
    VK_UNSIGNED = 3'd2,
    VK_SIGNED   = 3'd3,
    VK_FLOAT    = 3'd4,
    VK_BYTES    = 3'd5
  } value_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  attribute_id;
    logic [7:0]   data_type;
    value_kind_t  value_kind;
    logic [63:0]  value_bits;
    logic [15:0]  bytes_offset;
    logic [15:0]  bytes_length;
    logic         last;
  } result_t;

  // Byte count of a fixed-size type; 0 for the no-value type and for non-fixed codes
  function automatic logic [3:0] fixed_size(input logic [7:0] t);
    logic [3:0] sz;
    sz = 4'd0;
    case (t) inside
      [8'h08:8'h0F], [8'h18:8'h2F]: sz = {1'b0, t[2:0]} + 4'd1;
      8'h10, 8'h30:                 sz = 4'd1;
      8'h31, 8'h38:                 sz = 4'd2;
      8'h39:                        sz = 4'd4;
      8'h3A:                        sz = 4'd8;
      default:                      sz = 4'd0;
    endcase
    return sz;
  endfunction

  function automatic logic is_string(input logic [7:0] t);
    return (t == DT_OCTSTR) || (t == DT_CHARSTR) || (t == DT_LOCTSTR) ||
           (t == DT_LCHARSTR);
  endfunction

endpackage

### rtl/zcl_arp_parser.sv
// Input register and per-byte record parser; yields up to two results per byte.
module zcl_arp_parser #(
  parameter int POSITION_BITS = zcl_arp_pkg::POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_end,
  input  logic                 frame_format,
  input  logic                 room,
  output logic [1:0]           push_n,
  output zcl_arp_pkg::result_t res0,
  output zcl_arp_pkg::result_t res1
);

  typedef enum logic [7:0] {
    PH_ID_LO   = 8'b0000_0001,
    PH_ID_HI   = 8'b0000_0010,
    PH_TOS     = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_FIXED   = 8'b0001_0000,
    PH_LEN_LO  = 8'b0010_0000,
    PH_LEN_HI  = 8'b0100_0000,
    PH_STRING  = 8'b1000_0000
  } phase_t;

  logic                     iv_r, iv_nxt;
  logic [7:0]               b_r;
  logic                     end_r;
  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]              id_r, id_nxt;
  logic [7:0]               type_r, type_nxt;
  logic [15:0]              rem_r, rem_nxt;
  logic [63:0]              acc_r, acc_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic                     err_r, err_nxt;

  logic                     fire;
  logic                     begin_v;
  logic [7:0]               bv_type;
  logic [3:0]               bv_size;
  logic                     emit;
  logic                     ok;
  logic [15:0]              rem_dec;
  logic [15:0]              str_len;
  logic [POSITION_BITS-1:0] off_p;
  zcl_arp_pkg::value_kind_t vkind;
  logic [63:0]              vbits;
  logic [15:0]              voff;
  logic [15:0]              vlen;
  zcl_arp_pkg::result_t     rec;
  zcl_arp_pkg::result_t     endres;

  assign fire     = iv_r && room;
  assign in_ready = !iv_r || fire;
  assign iv_nxt   = in_valid ? 1'b1 : (iv_r && !fire);
  assign rem_dec  = rem_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    id_nxt    = id_r;
    type_nxt  = type_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    begin_v   = 1'b0;
    bv_type   = b_r;
    bv_size   = zcl_arp_pkg::fixed_size(b_r);
    emit      = 1'b0;
    str_len   = 16'd0;
    vkind     = zcl_arp_pkg::VK_NONE;
    vbits     = '0;
    voff      = '0;
    vlen      = '0;
    off_p     = '0;

    if (!err_r) begin
      case (phase_r)
        PH_ID_LO: begin
          id_nxt    = {8'h00, b_r};
          phase_nxt = PH_ID_HI;
        end
        PH_ID_HI: begin
          id_nxt    = {b_r, id_r[7:0]};
          phase_nxt = PH_TOS;
        end
        PH_TOS: begin
          if (!frame_format) begin
            begin_v = 1'b1;
          end else if (b_r == 8'h00) begin
            phase_nxt = PH_TYPE;
          end else begin
            phase_nxt = PH_ID_LO;   // nonzero status: record skipped
          end
        end
        PH_TYPE: begin
          begin_v = 1'b1;
        end
        PH_FIXED: begin
          for (int k = 0; k < 8; k++) begin
            if (idx_r == 3'(k)) acc_nxt[8*k +: 8] = b_r;
          end
          idx_nxt = idx_r + 3'd1;
          rem_nxt = rem_dec;
          if (rem_dec == 16'd0) begin
            emit      = 1'b1;
            phase_nxt = PH_ID_LO;
            vbits     = acc_nxt;
            if (type_r == zcl_arp_pkg::DT_BOOL) begin
              vkind = zcl_arp_pkg::VK_BOOL;
              vbits = {63'b0, (acc_nxt != 64'd0)};
            end else if (type_r >= zcl_arp_pkg::DT_INT8 &&
                         type_r <= zcl_arp_pkg::DT_INT64) begin
              vkind = zcl_arp_pkg::VK_SIGNED;
              // last byte carries the sign; fill the bytes above it
              for (int k = 0; k < 8; k++) begin
                if (3'(k) > idx_r) vbits[8*k +: 8] = {8{b_r[7]}};
              end
            end else if (type_r == zcl_arp_pkg::DT_FLOAT32) begin
              vkind = zcl_arp_pkg::VK_FLOAT;
            end else begin
              vkind = zcl_arp_pkg::VK_UNSIGNED;
            end
          end
        end
        PH_LEN_LO: begin
          acc_nxt = {56'b0, b_r};
          if (type_r == zcl_arp_pkg::DT_OCTSTR || type_r == zcl_arp_pkg::DT_CHARSTR) begin
            rem_nxt = {8'h00, b_r};
            if (b_r == 8'h00) begin
              emit    = 1'b1;
              str_len = 16'd0;
            end else begin
              phase_nxt = PH_STRING;
            end
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          acc_nxt = {48'b0, b_r, acc_r[7:0]};
          rem_nxt = {b_r, acc_r[7:0]};
          if ({b_r, acc_r[7:0]} == 16'd0) begin
            emit    = 1'b1;
            str_len = 16'd0;
          end else begin
            phase_nxt = PH_STRING;
          end
        end
        PH_STRING: begin
          rem_nxt = rem_dec;
          if (rem_dec == 16'd0) begin
            emit    = 1'b1;
            str_len = acc_r[15:0];
          end
        end
        default: begin
          phase_nxt = PH_ID_LO;
        end
      endcase

      // string record: offset points at the first string byte
      if (emit && (phase_r == PH_LEN_LO || phase_r == PH_LEN_HI ||
                   phase_r == PH_STRING)) begin
        phase_nxt = PH_ID_LO;
        off_p     = pos_r + POSITION_BITS'(1) - POSITION_BITS'(str_len);
        vkind     = zcl_arp_pkg::VK_BYTES;
        voff      = 16'(off_p);
        vlen      = str_len;
      end

      if (begin_v) begin
        type_nxt = bv_type;
        if (bv_size != 4'd0) begin
          acc_nxt   = '0;
          idx_nxt   = 3'd0;
          rem_nxt   = {12'b0, bv_size};
          phase_nxt = PH_FIXED;
        end else if (bv_type == zcl_arp_pkg::DT_NONE) begin
          emit      = 1'b1;
          phase_nxt = PH_ID_LO;
        end else if (zcl_arp_pkg::is_string(bv_type)) begin
          phase_nxt = PH_LEN_LO;
        end else begin
          err_nxt   = 1'b1;
          phase_nxt = PH_ID_LO;
        end
      end
    end

    pos_nxt = pos_r + POSITION_BITS'(1);
    ok      = !err_nxt && (phase_nxt == PH_ID_LO);

    rec              = '0;
    rec.kind         = zcl_arp_pkg::RK_RECORD;
    rec.attribute_id = id_nxt;
    rec.data_type    = type_nxt;
    rec.value_kind   = vkind;
    rec.value_bits   = vbits;
    rec.bytes_offset = voff;
    rec.bytes_length = vlen;
    rec.last         = !end_r;

    endres      = '0;
    endres.kind = ok ? zcl_arp_pkg::RK_END_OK : zcl_arp_pkg::RK_END_ERR;
    endres.last = 1'b1;

    if (end_r) begin
      phase_nxt = PH_ID_LO;
      pos_nxt   = '0;
      id_nxt    = '0;
      type_nxt  = '0;
      rem_nxt   = '0;
      acc_nxt   = '0;
      idx_nxt   = '0;
      err_nxt   = 1'b0;
    end

    res0   = '0;
    res1   = '0;
    push_n = 2'd0;
    if (fire) begin
      if (emit) begin
        res0   = rec;
        res1   = endres;
        push_n = end_r ? 2'd2 : 2'd1;
      end else if (end_r) begin
        res0   = endres;
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r    <= 1'b0;
      phase_r <= PH_ID_LO;
      pos_r   <= '0;
      id_r    <= '0;
      type_r  <= '0;
      rem_r   <= '0;
      acc_r   <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        id_r    <= id_nxt;
        type_r  <= type_nxt;
        rem_r   <= rem_nxt;
        acc_r   <= acc_nxt;
        idx_r   <= idx_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_r   <= in_byte;
      end_r <= in_end;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_r |=> phase_r == PH_ID_LO && !err_r && pos_r == '0)
    else $error("frame end did not clear parser state");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_ID_LO)
    else $error("parser left record start while in error");

  a_two_order: assert property (@(posedge clk) disable iff (!rst_n)
    push_n == 2'd2 |-> res0.kind == zcl_arp_pkg::RK_RECORD &&
                       res1.kind != zcl_arp_pkg::RK_RECORD && !res0.last && res1.last)
    else $error("record and end result pushed out of order");

endmodule

### rtl/zcl_arp_out_queue.sv
// Small result queue: takes up to two results per cycle, hands out one beat per cycle while out_ready is high.
module zcl_arp_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_n,
  input  zcl_arp_pkg::result_t res0,
  input  zcl_arp_pkg::result_t res1,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zcl_arp_pkg::result_t out_res
);

  localparam int DEPTH = zcl_arp_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  zcl_arp_pkg::result_t slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign out_res   = slot_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign room      = cnt_r <= CW'(DEPTH - 2);

  always_comb begin
    wr_nxt  = wr_r + PW'(push_n);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) slot_r[wr_r] <= res0;
    if (push_n == 2'd2) slot_r[wr_r + PW'(1)] <= res1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> room)
    else $error("push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push_n == 2'd0 |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("queue count wrong after pop");

endmodule

### rtl/zcl_attribute_record_parser.sv
// Top level of the attribute record parser: stream ports, APB register, parser and queue.
//
// Use: attribute record payload bytes enter on the in_ stream, one byte per
// beat, with in_tlast on the last byte of a frame (frames hold at least one byte).
// Each completed record leaves on the out_ stream as one beat with tuser = 0;
// after the last byte of a frame one more beat reports the frame result
// (tuser 1 ok, 2 error). out_tlast marks the last beat caused by one input byte.
// frame_format (APB register at address 0) picks report records (0) or read
// response records (1); write it only while the block is idle.
// Result path: a byte taken on in_ first lands in the input register, then the parse step
// writes its results into the result queue, from which they leave on the out_ stream.
// Throughput: one byte per cycle while the queue has room; a byte that closes a record
// and its frame makes two beats, which the four-entry result queue drains one per cycle
// while out_tready is high. The receiver may stall at any time: the queue fills, and
// in_tready drops while a byte waits in the input register with fewer than two queue
// entries free; nothing is lost.
// Reset (rst_n low, synchronous) clears the parse state, the frame position,
// the queue and frame_format.
module zcl_attribute_record_parser #(
  parameter int POSITION_BITS = zcl_arp_pkg::POSITION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tlast,    // frame_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] attribute_id, [23:16] data_type, [26:24] value_kind,
  // [90:27] value_bits, [106:91] bytes_offset, [122:107] bytes_length, rest zero
  output logic [zcl_arp_pkg::TDATA_OUT_BITS-1:0] out_tdata,
  output logic [1:0]   out_tuser,   // [1:0] result_kind
  output logic         out_tlast,   // last
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic                 fmt_r, fmt_nxt;
  logic                 room;
  logic [1:0]           push_n;
  zcl_arp_pkg::result_t res0, res1, head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'b0, fmt_r} : 32'd0;
  assign fmt_nxt    = (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       cfg_paddr[2] == 1'b0) ? cfg_pwdata[0] : fmt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  zcl_arp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_byte      (in_tdata),
    .in_end       (in_tlast),
    .frame_format (fmt_r),
    .room         (room),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1)
  );

  zcl_arp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign out_tuser = head.kind;
  assign out_tlast = head.last;
  assign out_tdata = {5'b0, head.bytes_length, head.bytes_offset, head.value_bits,
                      head.value_kind, head.data_type, head.attribute_id};

endmodule
